@@ src/mct_pkg.sv @@
// Shared types and constants for the multiset count table.
// Used by the controller, datapath, top level and port checker.
`default_nettype none

package mct_pkg;

    // fixed field widths of the input and result words
    localparam int OP_W       = 2;
    localparam int ELEM_W     = 32;
    localparam int AMOUNT_W   = 16;
    localparam int STATUS_W   = 2;
    localparam int RES_W      = 16;
    localparam int TOTAL_W    = 20;
    localparam int DISTINCT_W = 5;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_QUERY  = 2'd2,
        OP_TAKE   = 2'd3
    } op_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_ABSENT  = 2'd1,
        ST_NO_ROOM = 2'd2
    } status_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic scan;
        logic fetch_last;
        logic apply;
    } mct_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } mct_stat_t;

endpackage

`default_nettype wire

@@ src/mct_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module mct_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, data holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ src/mct_ctrl.sv @@
// Sequencer for the multiset count table: accept, scan, fetch last, apply.
// Depends on mct_pkg for the command and status structs.
`default_nettype none

module mct_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    output mct_pkg::mct_cmd_t        cmd,
    input  wire mct_pkg::mct_stat_t  stat
);
    import mct_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_APPLY
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // commands decoded from the current state
    assign in_stall       = (state_reg != S_IDLE);
    assign cmd.load       = (state_reg == S_IDLE) && in_valid;
    assign cmd.scan       = (state_reg == S_SCAN);
    assign cmd.fetch_last = (state_reg == S_LAST);
    assign cmd.apply      = (state_reg == S_APPLY) && stat.out_free;

endmodule

`default_nettype wire

@@ src/mct_dp.sv @@
// Datapath of the multiset count table: entry RAM, key scan, count update,
// swap-with-last on removal and the result register.
// Depends on mct_pkg and mct_ram.
`default_nettype none

module mct_dp #(
    parameter int CAPACITY   = 16,
    parameter int KEY_BITS   = 32,
    parameter int COUNT_BITS = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire mct_pkg::mct_cmd_t                cmd,
    output mct_pkg::mct_stat_t                    stat,
    input  wire logic [mct_pkg::OP_W-1:0]         operation,
    input  wire logic signed [mct_pkg::ELEM_W-1:0] element,
    input  wire logic [mct_pkg::AMOUNT_W-1:0]     amount,
    input  wire logic                             out_stall,
    output logic                                  out_valid,
    output logic [mct_pkg::STATUS_W-1:0]          status,
    output logic                                  found,
    output logic [mct_pkg::RES_W-1:0]             result_count,
    output logic [mct_pkg::TOTAL_W-1:0]           total_items,
    output logic                                  is_empty,
    output logic [mct_pkg::DISTINCT_W-1:0]        distinct_entries
);
    import mct_pkg::*;

    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int USED_W  = $clog2(CAPACITY + 1);
    localparam int SUM_W   = $clog2(CAPACITY) + COUNT_BITS;
    localparam int ENTRY_W = KEY_BITS + COUNT_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // latched item
    op_t                   op_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [AMOUNT_W-1:0]   amount_reg;

    // scan state
    logic [USED_W-1:0]     scan_idx_reg;
    logic                  cmp_valid_reg;
    logic                  hit_reg;
    logic [IDX_W-1:0]      slot_reg;
    logic [COUNT_BITS-1:0] slot_count_reg;

    // table bookkeeping
    logic [USED_W-1:0]     used_reg;
    logic [USED_W-1:0]     used_next;
    logic [SUM_W-1:0]      total_reg;
    logic [SUM_W-1:0]      total_next;

    // result register
    logic                  out_valid_reg;
    status_t               status_reg;
    logic                  found_reg;
    logic [RES_W-1:0]      result_count_reg;
    logic [TOTAL_W-1:0]    total_items_reg;
    logic                  is_empty_reg;
    logic [DISTINCT_W-1:0] distinct_reg;

    // ram ports
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [ENTRY_W-1:0]    ram_wdata;
    logic                  ram_re;
    logic [IDX_W-1:0]      ram_raddr;
    logic [ENTRY_W-1:0]    ram_rdata;

    logic [63:0]           elem_ext;
    logic [KEY_BITS-1:0]   rd_key;
    logic [USED_W-1:0]     last_idx;
    logic [USED_W-1:0]     prev_idx;
    logic                  match;
    logic                  issue;

    // update results
    status_t               new_status;
    logic [COUNT_BITS-1:0] new_res;
    logic [COUNT_BITS-1:0] cnt_dec;
    logic [COUNT_BITS-1:0] take;
    logic [COUNT_BITS-1:0] cnt_left;
    logic                  upd_we;
    logic [IDX_W-1:0]      upd_addr;
    logic [ENTRY_W-1:0]    upd_data;
    logic [31:0]           res_wide;
    logic [63:0]           total_wide;
    logic [31:0]           used_wide;

    // key: sign-extended element, low KEY_BITS kept
    assign elem_ext = {{(64 - ELEM_W){element[ELEM_W-1]}}, element};

    assign rd_key   = ram_rdata[ENTRY_W-1:COUNT_BITS];
    assign last_idx = used_reg - USED_W'(1);
    assign prev_idx = scan_idx_reg - USED_W'(1);

    // one compare per cycle against the entry read last cycle
    assign match = cmp_valid_reg && (rd_key == key_reg);
    assign issue = cmd.scan && (scan_idx_reg < used_reg) && !match;

    assign stat.scan_done = (cmp_valid_reg && (match || (scan_idx_reg == used_reg)))
                          || (!cmp_valid_reg && (scan_idx_reg >= used_reg));
    assign stat.out_free  = !out_valid_reg || !out_stall;

    // ram read address: scan pointer or last used entry
    assign ram_re    = issue || (cmd.fetch_last && (used_reg != '0));
    assign ram_raddr = cmd.scan ? scan_idx_reg[IDX_W-1:0] : last_idx[IDX_W-1:0];
    assign ram_we    = cmd.apply && upd_we;
    assign ram_waddr = upd_addr;
    assign ram_wdata = upd_data;

    mct_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_mct_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // amount clipped to the stored count
    always_comb
    begin
        if (32'(slot_count_reg) < 32'(amount_reg))
        begin
            take = slot_count_reg;
        end
        else
        begin
            take = COUNT_BITS'(amount_reg);
        end
    end

    assign cnt_dec  = slot_count_reg - COUNT_BITS'(1);
    assign cnt_left = slot_count_reg - take;

    // update of the found entry or a new entry appended on add, with swap-with-last when a count hits zero
    // ram_rdata holds the last used entry during apply
    always_comb
    begin
        new_status = ST_DONE;
        new_res    = '0;
        upd_we     = 1'b0;
        upd_addr   = slot_reg;
        upd_data   = {key_reg, slot_count_reg};
        used_next  = used_reg;
        total_next = total_reg;
        unique case (op_reg)
            OP_ADD:
            begin
                if (hit_reg)
                begin
                    if (slot_count_reg == COUNT_MAX)
                    begin
                        new_status = ST_NO_ROOM;
                        new_res    = slot_count_reg;
                    end
                    else
                    begin
                        new_res    = slot_count_reg + COUNT_BITS'(1);
                        upd_we     = 1'b1;
                        upd_data   = {key_reg, new_res};
                        total_next = total_reg + SUM_W'(1);
                    end
                end
                else if (used_reg == USED_W'(CAPACITY))
                begin
                    new_status = ST_NO_ROOM;
                end
                else
                begin
                    new_res    = COUNT_BITS'(1);
                    upd_we     = 1'b1;
                    upd_addr   = used_reg[IDX_W-1:0];
                    upd_data   = {key_reg, COUNT_BITS'(1)};
                    used_next  = used_reg + USED_W'(1);
                    total_next = total_reg + SUM_W'(1);
                end
            end
            OP_REMOVE:
            begin
                if (!hit_reg)
                begin
                    new_status = ST_ABSENT;
                end
                else
                begin
                    new_res    = cnt_dec;
                    upd_we     = 1'b1;
                    total_next = total_reg - SUM_W'(1);
                    if (cnt_dec == '0)
                    begin
                        upd_data  = ram_rdata;
                        used_next = last_idx;
                    end
                    else
                    begin
                        upd_data = {key_reg, cnt_dec};
                    end
                end
            end
            OP_QUERY:
            begin
                if (!hit_reg)
                begin
                    new_status = ST_ABSENT;
                end
                else
                begin
                    new_res = slot_count_reg;
                end
            end
            OP_TAKE:
            begin
                if (!hit_reg)
                begin
                    new_status = ST_ABSENT;
                end
                else
                begin
                    new_res    = take;
                    upd_we     = 1'b1;
                    total_next = total_reg - SUM_W'(take);
                    if (cnt_left == '0)
                    begin
                        upd_data  = ram_rdata;
                        used_next = last_idx;
                    end
                    else
                    begin
                        upd_data = {key_reg, cnt_left};
                    end
                end
            end
            default:
            begin
                new_status = ST_DONE;
            end
        endcase
    end

    // results masked to the field widths
    assign res_wide   = 32'(new_res);
    assign total_wide = 64'(total_next);
    assign used_wide  = 32'(used_next);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg  <= '0;
            cmp_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            used_reg      <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                scan_idx_reg  <= '0;
                cmp_valid_reg <= 1'b0;
                hit_reg       <= 1'b0;
            end
            else if (cmd.scan)
            begin
                cmp_valid_reg <= issue;
                if (issue)
                begin
                    scan_idx_reg <= scan_idx_reg + USED_W'(1);
                end
                if (match)
                begin
                    hit_reg <= 1'b1;
                end
            end

            if (cmd.apply)
            begin
                used_reg  <= used_next;
                total_reg <= total_next;
            end

            if (cmd.apply)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= op_t'(operation);
            key_reg    <= elem_ext[KEY_BITS-1:0];
            amount_reg <= amount;
        end
        if (cmd.scan && match)
        begin
            slot_reg       <= prev_idx[IDX_W-1:0];
            slot_count_reg <= ram_rdata[COUNT_BITS-1:0];
        end
        if (cmd.apply)
        begin
            status_reg       <= new_status;
            found_reg        <= hit_reg;
            result_count_reg <= res_wide[RES_W-1:0];
            total_items_reg  <= total_wide[TOTAL_W-1:0];
            is_empty_reg     <= (total_next == '0);
            distinct_reg     <= used_wide[DISTINCT_W-1:0];
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign found            = found_reg;
    assign result_count     = result_count_reg;
    assign total_items      = total_items_reg;
    assign is_empty         = is_empty_reg;
    assign distinct_entries = distinct_reg;

endmodule

`default_nettype wire

@@ src/multiset_count_table.sv @@
// Multiset count table: a table of up to CAPACITY distinct keys, each with
// an occurrence count, taking one operation word (add one, remove one, query,
// remove up to amount) and returning one result word per operation. Each
// item is accepted, then the key scan compares stored entries in order: the
// slot index plus one entries on a hit, every used entry on a miss. The
// input is taken again once the result is loaded; a held result blocks the
// update. The key scan does one entry compare per cycle through the entry
// RAM's single read port and is followed by a read of the last entry and an
// update. One item is in work at a time; a finished result sits in the
// output register while the next word is accepted. Entries are kept packed;
// a count that drops to zero is replaced by the last used entry.
// Depends on mct_pkg, mct_ctrl, mct_dp and mct_ram.
`default_nettype none

module multiset_count_table #(
    parameter int CAPACITY   = 16,
    parameter int KEY_BITS   = 32,
    parameter int COUNT_BITS = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [mct_pkg::OP_W-1:0]          operation,
    input  wire logic signed [mct_pkg::ELEM_W-1:0] element,
    input  wire logic [mct_pkg::AMOUNT_W-1:0]      amount,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [mct_pkg::STATUS_W-1:0]           status,
    output logic                                   found,
    output logic [mct_pkg::RES_W-1:0]              result_count,
    output logic [mct_pkg::TOTAL_W-1:0]            total_items,
    output logic                                   is_empty,
    output logic [mct_pkg::DISTINCT_W-1:0]         distinct_entries
);
    import mct_pkg::*;

    mct_cmd_t  cmd;
    mct_stat_t stat;

    // sequencer
    mct_ctrl u_mct_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .stat     (stat)
    );

    // table, scan and result register
    mct_dp #(
        .CAPACITY   (CAPACITY),
        .KEY_BITS   (KEY_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_mct_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .operation        (operation),
        .element          (element),
        .amount           (amount),
        .out_stall        (out_stall),
        .out_valid        (out_valid),
        .status           (status),
        .found            (found),
        .result_count     (result_count),
        .total_items      (total_items),
        .is_empty         (is_empty),
        .distinct_entries (distinct_entries)
    );

endmodule

`default_nettype wire

@@ src/mct_checker.sv @@
// Port-level checks for the multiset count table, bound to the top level.
// Depends on mct_pkg for the status codes.
`default_nettype none

module mct_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    input  wire logic                              in_stall,
    input  wire logic                              out_valid,
    input  wire logic                              out_stall,
    input  wire logic [mct_pkg::STATUS_W-1:0]      status,
    input  wire logic                              found,
    input  wire logic [mct_pkg::RES_W-1:0]         result_count,
    input  wire logic [mct_pkg::TOTAL_W-1:0]       total_items
);
    import mct_pkg::*;

    // a held result word keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_count)
                                   && $stable(total_items) && $stable(status))
    else $error("held result word changed");

    // an accepted word blocks the input while it is in work
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in work");

    // an absent key never reports found
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_ABSENT) |-> !found)
    else $error("absent status with found set");

    // a failed operation on a key not found gives a zero count
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found && (status != ST_DONE) |-> (result_count == '0))
    else $error("nonzero count for a key not found");

endmodule

bind multiset_count_table mct_checker u_mct_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .found        (found),
    .result_count (result_count),
    .total_items  (total_items)
);

`default_nettype wire
